// ----- sv/sbps_pkg.sv -----
package sbps_pkg;

  localparam int unsigned BLK_W    = 12;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned PEAK_W   = 15;

  localparam logic [1:0] REQ_SCAN   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_RANGE = 2'd1;
  localparam logic [1:0] STAT_SCAN_DONE = 2'd2;

  localparam logic signed [SMP_W-1:0] PLACE_LOW  = -16'sd16000;
  localparam logic [PEAK_W-1:0]       PLACE_HIGH = 15'd16000;

  localparam logic [CNT_W-1:0] BLOCK_SIZE_RST = 13'd588;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_QUERY,
    ST_QDONE
  } state_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] lmin;
    logic [PEAK_W-1:0]       lmax;
    logic signed [SMP_W-1:0] rmin;
    logic [PEAK_W-1:0]       rmax;
  } peaks_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic                    end_of_data;
    logic [BLK_W-1:0]        first_block;
    logic [BLK_W-1:0]        last_block;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [BLK_W-1:0]        block_index;
    logic signed [SMP_W-1:0] left_min;
    logic [PEAK_W-1:0]       left_max;
    logic signed [SMP_W-1:0] right_min;
    logic [PEAK_W-1:0]       right_max;
  } rsp_t;

endpackage

// ----- sv/stereo_block_peak_store.sv -----
// Stereo block peak store: min/max overview of stereo 16-bit audio.
// Requests enter on in_valid/in_ready (in_req), results leave on
// out_valid/out_ready (out_rsp); block_size is written on cfg_valid/cfg_data.
// Scan start: result in the cycle after acceptance; with a valid range the
//   range is then filled with placeholders through the single memory write
//   port, one block per cycle, while in_ready is low.
// Sample: one per cycle while in_ready is high; a closing sample writes its
//   block and presents the result in the next cycle; other samples give no result.
// Query over n blocks: the peak memory is read one block per cycle with a
//   registered read, and the merged result is loaded in ST_QDONE;
//   a query outside the valid blocks or with first above last answers in the next cycle.
// A single output register holds the result; while it is full and out_ready
//   is low, in_ready is low. It is released in the cycle it is taken.
// Reset: block_size 588, no valid blocks, no scan active, running peaks
//   zero. Peak memory contents are undefined until written by a scan.
module stereo_block_peak_store #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbps_pkg::req_t      in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output sbps_pkg::rsp_t      out_rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [12:0]         cfg_data
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  sbps_pkg::peaks_t mem [MAX_BLOCKS];

  sbps_pkg::state_t state_r, state_nxt;

  logic [sbps_pkg::CNT_W-1:0] block_size_r;
  logic [sbps_pkg::CNT_W-1:0] valid_r;
  logic [sbps_pkg::BLK_W-1:0] scan_block_r;
  logic [sbps_pkg::BLK_W-1:0] scan_last_r;
  logic                       scan_active_r;
  logic [sbps_pkg::CNT_W-1:0] cnt_r;
  sbps_pkg::peaks_t           run_r;
  logic                       out_valid_r;
  logic                       rd_pend_r;

  logic [sbps_pkg::BLK_W-1:0] fill_addr_r;
  logic [sbps_pkg::BLK_W-1:0] q_addr_r;
  logic [sbps_pkg::BLK_W-1:0] q_last_r;
  logic [sbps_pkg::BLK_W-1:0] q_first_r;
  sbps_pkg::peaks_t           acc_r;
  sbps_pkg::peaks_t           rd_q_r;
  sbps_pkg::rsp_t             out_r;

  logic                       accept;
  sbps_pkg::peaks_t           smp_pk;
  sbps_pkg::peaks_t           run_fold;
  sbps_pkg::peaks_t           zero_pk;
  sbps_pkg::peaks_t           place_pk;
  logic [sbps_pkg::CNT_W-1:0] cnt_inc;
  logic [sbps_pkg::CNT_W-1:0] limit;
  logic                       blk_close;
  logic                       blk_done;
  logic                       scan_ok;
  logic                       query_ok;
  logic [sbps_pkg::CNT_W-1:0] last_inc;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  sbps_pkg::peaks_t           mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic                       out_load;
  sbps_pkg::rsp_t             out_nxt;

  function automatic sbps_pkg::peaks_t peak_merge(sbps_pkg::peaks_t a, sbps_pkg::peaks_t b);
    sbps_pkg::peaks_t m;
    m.lmin = ($signed(b.lmin) < $signed(a.lmin)) ? b.lmin : a.lmin;
    m.rmin = ($signed(b.rmin) < $signed(a.rmin)) ? b.rmin : a.rmin;
    m.lmax = (b.lmax > a.lmax) ? b.lmax : a.lmax;
    m.rmax = (b.rmax > a.rmax) ? b.rmax : a.rmax;
    return m;
  endfunction

  function automatic sbps_pkg::rsp_t make_rsp(logic [1:0] st, logic [sbps_pkg::BLK_W-1:0] idx,
                                              sbps_pkg::peaks_t p);
    sbps_pkg::rsp_t r;
    r.status      = st;
    r.block_index = idx;
    r.left_min    = p.lmin;
    r.left_max    = p.lmax;
    r.right_min   = p.rmin;
    r.right_max   = p.rmax;
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == sbps_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  always_comb begin
    zero_pk  = '0;
    place_pk.lmin = sbps_pkg::PLACE_LOW;
    place_pk.rmin = sbps_pkg::PLACE_LOW;
    place_pk.lmax = sbps_pkg::PLACE_HIGH;
    place_pk.rmax = sbps_pkg::PLACE_HIGH;

    smp_pk.lmin = in_req.left_sample[sbps_pkg::SMP_W-1] ? in_req.left_sample : '0;
    smp_pk.lmax = in_req.left_sample[sbps_pkg::SMP_W-1] ? '0 :
                  in_req.left_sample[sbps_pkg::PEAK_W-1:0];
    smp_pk.rmin = in_req.right_sample[sbps_pkg::SMP_W-1] ? in_req.right_sample : '0;
    smp_pk.rmax = in_req.right_sample[sbps_pkg::SMP_W-1] ? '0 :
                  in_req.right_sample[sbps_pkg::PEAK_W-1:0];
    run_fold = peak_merge(run_r, smp_pk);

    cnt_inc   = cnt_r + 1'b1;
    limit     = (block_size_r == '0) ? {{(sbps_pkg::CNT_W-1){1'b0}}, 1'b1} : block_size_r;
    blk_close = (cnt_inc >= limit) || in_req.end_of_data;
    blk_done  = in_req.end_of_data || (scan_block_r >= scan_last_r);

    scan_ok  = (in_req.last_block >= in_req.first_block)
            && (32'(in_req.first_block) < MAX_BLOCKS)
            && (32'(in_req.last_block) < MAX_BLOCKS);
    query_ok = ({1'b0, in_req.first_block} < valid_r)
            && ({1'b0, in_req.last_block} < valid_r)
            && (in_req.first_block <= in_req.last_block);
    last_inc = {1'b0, in_req.last_block} + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbps_pkg::ST_IDLE: begin
        if (accept && in_req.req_type == sbps_pkg::REQ_SCAN && scan_ok) begin
          state_nxt = sbps_pkg::ST_FILL;
        end else if (accept && in_req.req_type == sbps_pkg::REQ_QUERY && query_ok) begin
          state_nxt = sbps_pkg::ST_QUERY;
        end
      end
      sbps_pkg::ST_FILL: begin
        if (fill_addr_r == scan_last_r) state_nxt = sbps_pkg::ST_IDLE;
      end
      sbps_pkg::ST_QUERY: begin
        if (q_addr_r == q_last_r) state_nxt = sbps_pkg::ST_QDONE;
      end
      sbps_pkg::ST_QDONE: begin
        state_nxt = sbps_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sbps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(fill_addr_r);
    mem_wdata = place_pk;
    mem_raddr = AW'(q_addr_r);
    out_load  = 1'b0;
    out_nxt   = make_rsp(sbps_pkg::STAT_OK, in_req.first_block, zero_pk);
    unique case (state_r)
      sbps_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req.req_type)
            sbps_pkg::REQ_SCAN: begin
              out_load = 1'b1;
              out_nxt  = make_rsp(scan_ok ? sbps_pkg::STAT_OK : sbps_pkg::STAT_BAD_RANGE,
                                  in_req.first_block, zero_pk);
            end
            sbps_pkg::REQ_SAMPLE: begin
              if (scan_active_r && blk_close) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(scan_block_r);
                mem_wdata = run_fold;
                out_load  = 1'b1;
                out_nxt   = make_rsp(blk_done ? sbps_pkg::STAT_SCAN_DONE : sbps_pkg::STAT_OK,
                                     scan_block_r, run_fold);
              end
            end
            sbps_pkg::REQ_QUERY: begin
              out_load = !query_ok;
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      sbps_pkg::ST_FILL: begin
        mem_we = 1'b1;
      end
      sbps_pkg::ST_QUERY: begin
        mem_we = 1'b0;
      end
      sbps_pkg::ST_QDONE: begin
        out_load = 1'b1;
        out_nxt  = make_rsp(sbps_pkg::STAT_OK, q_first_r, peak_merge(acc_r, rd_q_r));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sbps_pkg::ST_IDLE;
      block_size_r  <= sbps_pkg::BLOCK_SIZE_RST;
      valid_r       <= '0;
      scan_block_r  <= '0;
      scan_last_r   <= '0;
      scan_active_r <= 1'b0;
      cnt_r         <= '0;
      run_r         <= '0;
      out_valid_r   <= 1'b0;
      rd_pend_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == sbps_pkg::ST_QUERY);
      if (cfg_valid) begin
        block_size_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_req.req_type == sbps_pkg::REQ_SCAN && scan_ok) begin
        if (last_inc > valid_r) valid_r <= last_inc;
        scan_block_r  <= in_req.first_block;
        scan_last_r   <= in_req.last_block;
        scan_active_r <= 1'b1;
        cnt_r         <= '0;
        run_r         <= '0;
      end else if (accept && in_req.req_type == sbps_pkg::REQ_SAMPLE && scan_active_r) begin
        if (blk_close) begin
          cnt_r <= '0;
          run_r <= '0;
          if (blk_done) begin
            scan_active_r <= 1'b0;
          end else begin
            scan_block_r <= scan_block_r + 1'b1;
          end
        end else begin
          cnt_r <= cnt_inc;
          run_r <= run_fold;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (accept && in_req.req_type == sbps_pkg::REQ_SCAN) begin
      fill_addr_r <= in_req.first_block;
    end else if (state_r == sbps_pkg::ST_FILL) begin
      fill_addr_r <= fill_addr_r + 1'b1;
    end
    if (accept && in_req.req_type == sbps_pkg::REQ_QUERY) begin
      q_addr_r  <= in_req.first_block;
      q_first_r <= in_req.first_block;
      q_last_r  <= in_req.last_block;
      acc_r     <= '0;
    end else if (state_r == sbps_pkg::ST_QUERY) begin
      q_addr_r <= q_addr_r + 1'b1;
      if (rd_pend_r) begin
        acc_r <= peak_merge(acc_r, rd_q_r);
      end
    end
  end

endmodule
